FILE: hw/rtl/fwvr_pkg.sv
// ---------------------------------------------------------------------------
// fwvr_pkg: shared types and constants for the value-removal FIFO
// Request and status codes, default sizes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwvr_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request codes (s_tuser)
    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_CNT = 2'd2,
        REQ_REM = 2'd3
    } req_t;

    // completion status codes (m_tuser)
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } sts_code_t;

    // controller -> datapath commands
    typedef struct packed {
        logic start;       // latch request, clear per-request counters
        logic enq;         // append operand at tail
        logic deq_issue;   // start head read (or flag empty)
        logic deq_take;    // consume read data, advance head
        logic scan_step;   // one step of the count/remove walk
        logic scan_end;    // commit compacted fill level
        logic load_out;    // load the output register
    } fwvr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        req_t op;
        logic empty;
        logic scan_done;
    } fwvr_sts_t;

endpackage

FILE: hw/rtl/fifo_with_value_removal.sv
// ---------------------------------------------------------------------------
// fifo_with_value_removal: bounded FIFO with count and remove by value
//
// Input stream: s_tuser carries the request (enqueue, dequeue, count,
// remove), s_tdata the operand. One request is taken at a time; s_tready is
// high only while the sequencer is idle.
// Output stream: one transaction per request, held in an output register.
// m_tuser carries the status, m_tdata the dequeued value, match count and
// fill level after the request.
// From accept to m_tvalid: enqueue runs execute and finish; dequeue runs
// execute, read and finish (no read on an empty queue); count and remove
// run execute, a scan reading one entry per cycle from the single-read-port
// entry RAM, then retire and commit, then finish. A new request is taken once
// the result is loaded; the input side is free again while a result waits.
// Reset clears the pointers (queue empty) and the sequencer; the entry RAM
// is not cleared and needs no clearing pass.
// When the receiver stalls, the finished result stays on m_tdata/m_tuser,
// and a following request completes up to its hand-off, then waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_with_value_removal #(
    parameter int DEPTH      = fwvr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fwvr_pkg::DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // operand_value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]                       s_tdata,
    // req_type
    input  logic [1:0]                                            s_tuser,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // out_value, match_count, fill_out
    output logic [((DATA_WIDTH+2*$clog2(DEPTH+1)+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [1:0]                                            m_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready
);

    import fwvr_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((DATA_WIDTH + 2*CW + 7) / 8) * 8;

    fwvr_cmd_t             cmd;
    fwvr_sts_t             sts;
    logic [DATA_WIDTH-1:0] res_value;
    logic [CW-1:0]         res_match;
    logic [1:0]            res_status;
    logic [CW-1:0]         res_fill;

    fwvr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    fwvr_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .req_in     (s_tuser),
        .operand_in (s_tdata[DATA_WIDTH-1:0]),
        .res_value  (res_value),
        .res_match  (res_match),
        .res_status (res_status),
        .res_fill   (res_fill)
    );

    // pack result fields from the low end, zero padded to whole bytes
    assign m_tdata = OUT_W'({res_fill, res_match, res_value});
    assign m_tuser = res_status;

endmodule

FILE: hw/rtl/fwvr_ram.sv
// ---------------------------------------------------------------------------
// fwvr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fwvr_dp.sv
// ---------------------------------------------------------------------------
// fwvr_dp: datapath of the value-removal FIFO
// Head/fill pointers, entry RAM, scan counters and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwvr_dp #(
    parameter int DEPTH      = fwvr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fwvr_pkg::DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fwvr_pkg::fwvr_cmd_t   cmd,
    output fwvr_pkg::fwvr_sts_t   sts,
    input  logic [1:0]            req_in,
    input  logic [DATA_WIDTH-1:0] operand_in,
    output logic [DATA_WIDTH-1:0] res_value,
    output logic [CW-1:0]         res_match,
    output logic [1:0]            res_status,
    output logic [CW-1:0]         res_fill
);

    import fwvr_pkg::*;

    // queue pointers
    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         fill_reg;
    // latched request
    req_t                  op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    // per-request working registers
    sts_code_t             status_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CW-1:0]         issue_reg;
    logic                  pend_reg;
    logic [CW-1:0]         kept_reg;
    logic [CW-1:0]         match_reg;
    // output register
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic [CW-1:0]         out_match_reg;
    sts_code_t             out_status_reg;
    logic [CW-1:0]         out_fill_reg;

    logic                  full;
    logic                  empty;
    logic                  hit;
    logic                  issue;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // physical slot of a logical offset from the head: one compare/subtract
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (fill_reg == CW'(DEPTH));
    assign empty = (fill_reg == '0);
    assign hit   = (ram_rdata == val_reg);
    assign issue = cmd.scan_step && (issue_reg != fill_reg);

    // RAM port steering
    always_comb begin
        ram_we    = (cmd.enq && !full) ||
                    (cmd.scan_step && pend_reg && !hit && (op_reg == REQ_REM));
        ram_waddr = cmd.enq ? slot_of(head_reg, fill_reg) : slot_of(head_reg, kept_reg);
        ram_wdata = cmd.enq ? val_reg : ram_rdata;
        ram_re    = (cmd.deq_issue && !empty) || issue;
        ram_raddr = cmd.deq_issue ? head_reg : slot_of(head_reg, issue_reg);
    end

    fwvr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // pointers and pipeline flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                pend_reg <= 1'b0;
            end
            if (cmd.enq && !full) begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.deq_take) begin
                head_reg <= slot_of(head_reg, CW'(1));
                fill_reg <= fill_reg - CW'(1);
            end
            if (cmd.scan_step) begin
                pend_reg <= issue;
            end
            if (cmd.scan_end && (op_reg == REQ_REM)) begin
                fill_reg <= kept_reg;
            end
        end
    end

    // request payload, counters and result register
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg     <= req_t'(req_in);
            val_reg    <= operand_in;
            status_reg <= STS_OK;
            value_reg  <= '0;
            issue_reg  <= '0;
            kept_reg   <= '0;
            match_reg  <= '0;
        end
        if (cmd.enq && full) begin
            status_reg <= STS_FULL;
        end
        if (cmd.deq_issue && empty) begin
            status_reg <= STS_EMPTY;
        end
        if (cmd.deq_take) begin
            value_reg <= ram_rdata;
        end
        // scan: issue one read and retire the previous one each cycle
        if (cmd.scan_step) begin
            if (issue) begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (pend_reg) begin
                if (hit) begin
                    match_reg <= match_reg + CW'(1);
                end else begin
                    kept_reg <= kept_reg + CW'(1);
                end
            end
        end
        if (cmd.load_out) begin
            out_value_reg  <= value_reg;
            out_match_reg  <= match_reg;
            out_status_reg <= status_reg;
            out_fill_reg   <= fill_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.empty     = empty;
    assign sts.scan_done = !pend_reg && (issue_reg == fill_reg);

    assign res_value  = out_value_reg;
    assign res_match  = out_match_reg;
    assign res_status = out_status_reg;
    assign res_fill   = out_fill_reg;

endmodule

FILE: hw/rtl/fwvr_ctrl.sv
// ---------------------------------------------------------------------------
// fwvr_ctrl: request sequencer of the value-removal FIFO
// Accepts one transaction, steps the datapath through it and hands the
// result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwvr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output fwvr_pkg::fwvr_cmd_t cmd,
    input  fwvr_pkg::fwvr_sts_t sts
);

    import fwvr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // next state and command decode
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (sts.op)
                    REQ_ENQ: begin
                        cmd.enq    = 1'b1;
                        state_next = ST_FINISH;
                    end
                    REQ_DEQ: begin
                        cmd.deq_issue = 1'b1;
                        state_next    = sts.empty ? ST_FINISH : ST_READ;
                    end
                    default: begin
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_READ: begin
                cmd.deq_take = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule
